>>> rtl/core/cps_pkg.sv
// closest point on segment: shared word types and fixed-point format
// no dependencies
package cps_pkg;
	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] start_z;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic signed [COORD_BITS-1:0] end_z;
		logic signed [COORD_BITS-1:0] query_x;
		logic signed [COORD_BITS-1:0] query_y;
		logic signed [COORD_BITS-1:0] query_z;
	} seg_word_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] near_x;
		logic signed [COORD_BITS-1:0] near_y;
		logic signed [COORD_BITS-1:0] near_z;
		logic                         degenerate;
	} near_word_t;
endpackage

>>> rtl/core/cps_if.sv
// valid/ready channel carrying one word of payload type
// no dependencies
interface cps_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/cps_div.sv
// pipelined restoring divider, one quotient bit per stage
// operands are unsigned, num < den; uses no package items
module cps_div #(
	parameter int NW = 100,
	parameter int QW = 16,
	parameter int SW = 200
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);
	logic [NW-1:0] rem_s [QW];
	logic [NW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [NW-1:0] rem_in;
		logic [NW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic [SW-1:0] side_k;
		logic [NW:0]   sh;
		logic          ge;
		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
			assign side_k = side_in;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
			assign side_k = side_s[k-1];
		end
		assign sh = {rem_in, 1'b0};
		assign ge = sh >= {1'b0, den_in};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? NW'(sh - {1'b0, den_in}) : sh[NW-1:0];
				den_s[k]  <= den_in;
				quo_s[k]  <= {quo_in[QW-2:0], ge};
				side_s[k] <= side_k;
			end
		end
	end

	assign quo      = quo_s[QW-1];
	assign side_out = side_s[QW-1];
endmodule

>>> rtl/core/closest_point_on_segment_core.sv
// closest point on segment core: top level
// divider with 16 quotient stages by default, one word per cycle unless stalled
// throughput one word per cycle; a stall freezes the whole pipeline (global enable)
// the output register is part of the pipeline, ready flows back combinationally
// reset clears the valid bits only; no clearing pass
// depends on cps_pkg, cps_if, cps_div
module closest_point_on_segment_core #(
	parameter int T_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	cps_if.sink   in_ch,
	cps_if.source out_ch
);
	localparam int CW = cps_pkg::COORD_BITS;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int SWD = PW + 2;
	localparam int TW = T_FRAC_BITS + 1;
	localparam int NST = 7 + T_FRAC_BITS;

	logic en;
	logic [NST-1:0] vld_q;
	assign en = !vld_q[NST-1] || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_ch.valid};
		end
	end

	// stage 1: differences
	logic signed [CW-1:0] s_s1 [3];
	logic signed [DW-1:0] d_s1 [3], v_s1 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			s_s1[0] <= in_ch.data.start_x;
			s_s1[1] <= in_ch.data.start_y;
			s_s1[2] <= in_ch.data.start_z;
			d_s1[0] <= DW'(signed'(in_ch.data.end_x)) - DW'(signed'(in_ch.data.start_x));
			d_s1[1] <= DW'(signed'(in_ch.data.end_y)) - DW'(signed'(in_ch.data.start_y));
			d_s1[2] <= DW'(signed'(in_ch.data.end_z)) - DW'(signed'(in_ch.data.start_z));
			v_s1[0] <= DW'(signed'(in_ch.data.query_x)) - DW'(signed'(in_ch.data.start_x));
			v_s1[1] <= DW'(signed'(in_ch.data.query_y)) - DW'(signed'(in_ch.data.start_y));
			v_s1[2] <= DW'(signed'(in_ch.data.query_z)) - DW'(signed'(in_ch.data.start_z));
		end
	end

	// stage 2: products
	logic signed [CW-1:0] s_s2 [3];
	logic signed [DW-1:0] d_s2 [3];
	logic signed [PW-1:0] pn_s2 [3], pd_s2 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				s_s2[i]  <= s_s1[i];
				d_s2[i]  <= d_s1[i];
				pn_s2[i] <= PW'(d_s1[i]) * PW'(v_s1[i]);
				pd_s2[i] <= PW'(d_s1[i]) * PW'(d_s1[i]);
			end
		end
	end

	// stage 3: dot sums
	logic signed [CW-1:0] s_s3 [3];
	logic signed [DW-1:0] d_s3 [3];
	logic signed [SWD-1:0] num_s3;
	logic [SWD-1:0] den_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			s_s3 <= s_s2;
			d_s3 <= d_s2;
			num_s3 <= SWD'(pn_s2[0]) + SWD'(pn_s2[1]) + SWD'(pn_s2[2]);
			den_s3 <= SWD'(pd_s2[0]) + SWD'(pd_s2[1]) + SWD'(pd_s2[2]);
		end
	end

	// stage 4: classify
	logic signed [CW-1:0] s_s4 [3];
	logic signed [DW-1:0] d_s4 [3];
	logic [SWD-1:0] num_s4, den_s4;
	logic dg_s4, lo_s4, hi_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			s_s4 <= s_s3;
			d_s4 <= d_s3;
			dg_s4 <= den_s3 == '0;
			lo_s4 <= num_s3 <= 0;
			hi_s4 <= num_s3 > 0 && $unsigned(num_s3) >= den_s3;
			num_s4 <= (num_s3 > 0 && $unsigned(num_s3) < den_s3) ? $unsigned(num_s3) : '0;
			den_s4 <= (den_s3 == '0) ? SWD'(1) : den_s3;
		end
	end

	localparam int SIDE = 3 * CW + 3 * DW + 3;
	logic [SIDE-1:0] side_in, side_out;
	logic [T_FRAC_BITS-1:0] quo;
	assign side_in = {s_s4[0], s_s4[1], s_s4[2], d_s4[0], d_s4[1], d_s4[2],
		dg_s4, lo_s4, hi_s4};

	cps_div #(.NW(SWD), .QW(T_FRAC_BITS), .SW(SIDE)) u_div (
		.clk(clk), .en(en), .num(num_s4), .den(den_s4),
		.side_in(side_in), .quo(quo), .side_out(side_out)
	);

	logic signed [CW-1:0] s_d [3];
	logic signed [DW-1:0] d_d [3];
	logic dg_d, lo_d, hi_d;
	assign {s_d[0], s_d[1], s_d[2], d_d[0], d_d[1], d_d[2], dg_d, lo_d, hi_d} = side_out;

	// stage 5: t and magnitude
	logic signed [CW-1:0] s_s5 [3];
	logic [DW-1:0] ad_s5 [3];
	logic neg_s5 [3];
	logic [TW-1:0] t_s5;
	logic dg_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				s_s5[i]   <= s_d[i];
				neg_s5[i] <= d_d[i] < 0;
				ad_s5[i]  <= (d_d[i] < 0) ? DW'(-d_d[i]) : DW'(d_d[i]);
			end
			dg_s5 <= dg_d;
			t_s5 <= (dg_d || lo_d) ? '0 : hi_d ? TW'(1) << T_FRAC_BITS : {1'b0, quo};
		end
	end

	// stage 6: scale
	localparam int MW = DW + TW;
	logic signed [CW-1:0] s_s6 [3];
	logic [MW-1:0] m_s6 [3];
	logic neg_s6 [3];
	logic dg_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				s_s6[i]   <= s_s5[i];
				neg_s6[i] <= neg_s5[i];
				m_s6[i]   <= MW'(ad_s5[i]) * MW'(t_s5);
			end
			dg_s6 <= dg_s5;
		end
	end

	// stage 7: offset and output register
	logic [CW-1:0] n_s7 [3];
	logic dg_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n_s7[i] <= s_s6[i] + (neg_s6[i]
					? -CW'(m_s6[i] >> T_FRAC_BITS) : CW'(m_s6[i] >> T_FRAC_BITS));
			end
			dg_s7 <= dg_s6;
		end
	end

	assign out_ch.valid           = vld_q[NST-1];
	assign out_ch.data.near_x     = n_s7[0];
	assign out_ch.data.near_y     = n_s7[1];
	assign out_ch.data.near_z     = n_s7[2];
	assign out_ch.data.degenerate = dg_s7;
endmodule

>>> tb/closest_point_on_segment_core_tb.sv
// testbench for closest_point_on_segment_core: directed and random segment queries,
// checked word by word against a built-in projection predictor
// depends on cps_pkg, cps_if and the core
`timescale 1ns / 1ps
module closest_point_on_segment_core_tb;
	localparam int T_FRAC = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SINK_HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #10 clk = ~clk;

	cps_if #(.T(cps_pkg::seg_word_t)) in_ch ();
	cps_if #(.T(cps_pkg::near_word_t)) out_ch ();

	closest_point_on_segment_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	cps_pkg::near_word_t expected_points[$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int degenerate_seen = 0;
	int send_idle_pct = 0;
	int sink_idle_pct = 0;
	logic sink_hold_on = 1'b0;
	event sink_hold_go;
	int cycles = 0;

	function automatic cps_pkg::near_word_t project_point(cps_pkg::seg_word_t w);
		logic signed [33:0] s[3];
		logic signed [33:0] d[3];
		logic signed [33:0] v[3];
		logic signed [127:0] num;
		logic signed [127:0] den;
		logic [127:0] mag;
		logic [127:0] off;
		logic [127:0] t;
		logic signed [33:0] r[3];
		cps_pkg::near_word_t p;
		s[0] = w.start_x;
		s[1] = w.start_y;
		s[2] = w.start_z;
		d[0] = w.end_x - s[0];
		d[1] = w.end_y - s[1];
		d[2] = w.end_z - s[2];
		v[0] = w.query_x - s[0];
		v[1] = w.query_y - s[1];
		v[2] = w.query_z - s[2];
		num = 0;
		den = 0;
		for (int i = 0; i < 3; i++) begin
			num = num + 128'(d[i]) * 128'(v[i]);
			den = den + 128'(d[i]) * 128'(d[i]);
		end
		if (den == 0) begin
			p.near_x = w.start_x;
			p.near_y = w.start_y;
			p.near_z = w.start_z;
			p.degenerate = 1'b1;
			return p;
		end
		if (num <= 0)
			t = 0;
		else if (num >= den)
			t = 128'(1) << T_FRAC;
		else
			t = (num <<< T_FRAC) / den;
		for (int i = 0; i < 3; i++) begin
			mag = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
			off = (mag * t) >> T_FRAC;
			r[i] = (d[i] < 0) ? s[i] - 34'(off) : s[i] + 34'(off);
		end
		p.near_x = r[0][31:0];
		p.near_y = r[1][31:0];
		p.near_z = r[2][31:0];
		p.degenerate = 1'b0;
		return p;
	endfunction

	task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
		errors++;
		$display("mismatch %s at word %0d: expected %h got %h", what, words_checked, exp_v,
			got_v);
	endtask

	task automatic send_segment(cps_pkg::seg_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		do @(posedge clk); while (!in_ch.ready);
		expected_points.push_back(project_point(w));
		words_sent++;
		@(negedge clk);
	endtask

	// long receiver hold-off, counted here
	always begin
		@(sink_hold_go);
		sink_hold_on = 1'b1;
		repeat (SINK_HOLD_CYCLES) @(negedge clk);
		sink_hold_on = 1'b0;
	end

	// receive side: random ready, held low during reset and hold-off
	always @(negedge clk) begin
		if (!arst_n || sink_hold_on) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		cps_pkg::near_word_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_points.size() == 0) begin
				report("unexpected word", '0, '0);
			end else begin
				e = expected_points.pop_front();
				if (out_ch.data.near_x !== e.near_x) report("near_x", e.near_x, out_ch.data.near_x);
				if (out_ch.data.near_y !== e.near_y) report("near_y", e.near_y, out_ch.data.near_y);
				if (out_ch.data.near_z !== e.near_z) report("near_z", e.near_z, out_ch.data.near_z);
				if (out_ch.data.degenerate !== e.degenerate)
					report("degenerate", 32'(e.degenerate), 32'(out_ch.data.degenerate));
				if (e.degenerate) degenerate_seen++;
			end
			words_checked++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic logic signed [31:0] coord(int unsigned kind);
		case (kind)
			0: return $urandom();
			1: return $signed(32'($urandom_range(8191))) - 4096;
			2: return $signed(32'($urandom_range(32'h00ffffff))) - 32'sh00800000;
			default: return $signed(32'($urandom_range(65535) << 12)) - 32'sh08000000;
		endcase
	endfunction

	function automatic cps_pkg::seg_word_t random_segment();
		cps_pkg::seg_word_t w;
		int unsigned kind;
		int unsigned shape;
		kind = $urandom_range(3);
		shape = $urandom_range(19);
		w.start_x = coord(kind);
		w.start_y = coord(kind);
		w.start_z = coord(kind);
		w.end_x = coord(kind);
		w.end_y = coord(kind);
		w.end_z = coord(kind);
		w.query_x = coord(kind);
		w.query_y = coord(kind);
		w.query_z = coord(kind);
		if (shape == 0) begin
			w.end_x = w.start_x;
			w.end_y = w.start_y;
			w.end_z = w.start_z;
		end else if (shape == 1) begin
			w.query_x = w.start_x;
			w.query_y = w.start_y;
			w.query_z = w.start_z;
		end else if (shape == 2) begin
			w.query_x = w.end_x;
			w.query_y = w.end_y;
			w.query_z = w.end_z;
		end else if (shape < 10 && kind != 0) begin
			// query near the segment interior
			w.query_x = w.start_x + (w.end_x - w.start_x) / 2 + coord(1);
			w.query_y = w.start_y + (w.end_y - w.start_y) / 3 + coord(1);
			w.query_z = w.start_z + (w.end_z - w.start_z) / 4 + coord(1);
		end
		return w;
	endfunction

	function automatic cps_pkg::seg_word_t make_segment(logic signed [31:0] sx, sy, sz,
		ex, ey, ez, qx, qy, qz);
		cps_pkg::seg_word_t w;
		w = '{sx, sy, sz, ex, ey, ez, qx, qy, qz};
		return w;
	endfunction

	task automatic test_directed();
		localparam logic signed [31:0] MX = 32'sh7fffffff;
		localparam logic signed [31:0] MN = 32'sh80000000;
		localparam logic signed [31:0] ONE = 32'sh00010000;
		send_idle_pct = 0;
		sink_idle_pct = 0;
		send_segment(make_segment(0, 0, 0, 0, 0, 0, ONE, ONE, ONE));
		send_segment(make_segment(MX, MN, MX, MX, MN, MX, 0, 0, 0));
		send_segment(make_segment(0, 0, 0, 10 * ONE, 0, 0, -ONE, 5 * ONE, 0));
		send_segment(make_segment(0, 0, 0, 10 * ONE, 0, 0, 20 * ONE, 0, 3 * ONE));
		send_segment(make_segment(0, 0, 0, 10 * ONE, 0, 0, 10 * ONE, 0, 0));
		send_segment(make_segment(0, 0, 0, 10 * ONE, 0, 0, 0, 7 * ONE, 0));
		send_segment(make_segment(0, 0, 0, 3 * ONE, 0, 0, ONE, ONE, 0));
		send_segment(make_segment(ONE, ONE, ONE, -ONE, -ONE, -ONE, 0, 0, ONE));
		send_segment(make_segment(MN, MN, MN, MX, MX, MX, 0, 0, 0));
		send_segment(make_segment(MX, MX, MX, MN, MN, MN, 1, -1, 1));
		send_segment(make_segment(MN, MN, MN, MX, MX, MX, MX, MX, MX));
		send_segment(make_segment(MN, MN, MN, MX, MX, MX, MN, MN, MN));
		send_segment(make_segment(MN, 0, MX, MX, 0, MN, MN, MX, MN));
		send_segment(make_segment(0, 0, 0, 1, 0, 0, 0, 0, 0));
		send_segment(make_segment(0, 0, 0, 3, 0, 0, 1, 0, 0));
		send_segment(make_segment(0, 0, 0, 0, 0, -3, 0, 0, -2));
		send_segment(make_segment(-1, -1, -1, -1, -1, -1, MX, MX, MX));
		send_segment(make_segment(5, 7, 9, 5, 7, 10, MN, MN, MN));
		send_segment(make_segment(0, 0, 0, MX, 0, 0, MX, MX, MX));
		send_segment(make_segment(0, MX, 0, 0, MN, 0, ONE, 0, ONE));
	endtask

	task automatic test_random(int count, int send_pct, int sink_pct);
		send_idle_pct = send_pct;
		sink_idle_pct = sink_pct;
		repeat (count) send_segment(random_segment());
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		sink_idle_pct = 10;
		-> sink_hold_go;
		repeat (150) send_segment(random_segment());
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(600, 30, 74);
		test_random(600, 74, 30);
		test_backpressure();
		test_random(550, 0, 0);
		in_ch.valid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("sent %0d segment queries, checked %0d points, %0d degenerate", words_sent,
			words_checked, degenerate_seen);
		$display("covered field extremes, clamped ends, interior points and back-pressure");
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

>>> closest_point_on_segment_core.f
rtl/core/cps_pkg.sv
rtl/core/cps_if.sv
rtl/core/cps_div.sv
rtl/core/closest_point_on_segment_core.sv
tb/closest_point_on_segment_core_tb.sv
